[rtl/sfe_pkg.sv]
// Shared types and constants for the serial frame extractor.
package sfe_pkg;

  localparam int LONG_FRAME_BYTES_DEF = 9;
  localparam int SHORT_FRAME_BYTES    = 4;
  localparam int MAX_RESULTS          = 2;
  localparam int PAYLOAD_BYTES        = 6;
  localparam int CFG_INDEX_W          = 2;
  localparam int COUNT_W              = 2;

  localparam logic [7:0] HEADER_RESET = 8'd170;
  localparam logic [7:0] TIME_RESET   = 8'd1;
  localparam logic [7:0] TAIL_RESET   = 8'd85;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HEADER = 2'd0,
    CFG_TIME   = 2'd1,
    CFG_TAIL   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    SCAN_DROP,
    SCAN_ADVANCE,
    SCAN_EMIT_SHORT,
    SCAN_EMIT_LONG,
    SCAN_FAIL
  } scan_kind_t;

  typedef struct packed {
    logic [3:0]                 len;
    logic [7:0]                 command;
    logic [8*PAYLOAD_BYTES-1:0] payload;
  } frame_t;

  typedef struct packed {
    logic load;       // append accepted byte
    logic step;       // apply scan action
    logic keep;       // capture found frame into hold register
    logic push_held;  // move held frame to output register
    logic push_last;  // pushed frame ends the run
  } sfe_cmd_t;

  typedef struct packed {
    logic       done;
    scan_kind_t kind;
    logic       held_valid;
    logic       out_free;
  } sfe_status_t;

endpackage

[rtl/sfe_ctrl.sv]
// Controller state machine: sequences byte intake, scanning and frame delivery.
module sfe_ctrl
  import sfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  sfe_status_t status,
  output sfe_cmd_t    cmd
);

  state_t             state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               is_emit;
  logic               room;

  assign is_emit = (status.kind == SCAN_EMIT_SHORT) || (status.kind == SCAN_EMIT_LONG);
  assign room    = (count < COUNT_W'(MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          count_next = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.done) begin
          state_next = ST_FLUSH;
        end else if (is_emit && room) begin
          if (!status.held_valid || status.out_free) begin
            cmd.step       = 1'b1;
            cmd.keep       = 1'b1;
            cmd.push_held  = status.held_valid;
            count_next     = count + 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!status.held_valid) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.push_held = 1'b1;
          cmd.push_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/sfe_datapath.sv]
// Datapath: config registers, byte buffer with scan counters, hold and output registers.
module sfe_datapath
  import sfe_pkg::*;
#(
  parameter int LONG_FRAME_BYTES = LONG_FRAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [7:0]                 cfg_data,
  input  logic [7:0]                 rx_byte,
  input  sfe_cmd_t                   cmd,
  output sfe_status_t                status,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [3:0]                 frame_len,
  output logic [7:0]                 command,
  output logic [8*PAYLOAD_BYTES-1:0] payload,
  output logic                       last_of_run
);

  localparam int CW = $clog2(LONG_FRAME_BYTES + 1);
  localparam int IW = $clog2(LONG_FRAME_BYTES);
  localparam logic [3:0] LEN_LONG  = 4'(LONG_FRAME_BYTES);
  localparam logic [3:0] LEN_SHORT = 4'(SHORT_FRAME_BYTES);

  logic [7:0] header_byte, time_command, tail_byte;

  // buf_bytes[0 .. fill-1] is the open frame, buf_bytes[fill .. used-1] waits for rescan
  logic [7:0]    buf_bytes      [LONG_FRAME_BYTES];
  logic [7:0]    buf_bytes_next [LONG_FRAME_BYTES];
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] used, used_next;
  logic [CW-1:0] fill_inc;

  scan_kind_t kind;
  frame_t     found;
  frame_t     held;
  logic       held_valid;
  int         shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= HEADER_RESET;
      time_command <= TIME_RESET;
      tail_byte    <= TAIL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HEADER: header_byte  <= cfg_data;
        CFG_TIME:   time_command <= cfg_data;
        CFG_TAIL:   tail_byte    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fill_inc = fill + 1'b1;

  always_comb begin
    if (fill == '0 && buf_bytes[0] != header_byte) begin
      kind = SCAN_DROP;
    end else if (fill_inc == CW'(SHORT_FRAME_BYTES)) begin
      if (buf_bytes[3] == tail_byte) begin
        kind = SCAN_EMIT_SHORT;
      end else if (buf_bytes[1] != time_command) begin
        kind = SCAN_FAIL;
      end else begin
        kind = SCAN_ADVANCE;
      end
    end else if (fill_inc == CW'(LONG_FRAME_BYTES)) begin
      if (buf_bytes[LONG_FRAME_BYTES-1] == tail_byte) begin
        kind = SCAN_EMIT_LONG;
      end else begin
        kind = SCAN_FAIL;
      end
    end else begin
      kind = SCAN_ADVANCE;
    end
  end

  always_comb begin
    found         = '0;
    found.command = buf_bytes[1];
    if (kind == SCAN_EMIT_LONG) begin
      found.len = LEN_LONG;
      for (int j = 0; j < PAYLOAD_BYTES; j++) begin
        if (j + 3 < LONG_FRAME_BYTES) begin
          found.payload[8*j +: 8] = buf_bytes[j+2];
        end
      end
    end else begin
      found.len          = LEN_SHORT;
      found.payload[7:0] = buf_bytes[2];
    end
  end

  assign status.done       = (fill == used);
  assign status.kind       = kind;
  assign status.held_valid = held_valid;
  assign status.out_free   = !out_valid || !out_stall;

  always_comb begin
    fill_next = fill;
    used_next = used;
    shift     = 0;
    if (cmd.load) begin
      used_next = used + 1'b1;
    end else if (cmd.step) begin
      case (kind) inside
        SCAN_DROP, SCAN_FAIL: begin
          shift     = 1;
          used_next = used - 1'b1;
          fill_next = '0;
        end
        SCAN_EMIT_SHORT: begin
          shift     = SHORT_FRAME_BYTES;
          used_next = used - CW'(SHORT_FRAME_BYTES);
          fill_next = '0;
        end
        SCAN_EMIT_LONG: begin
          shift     = LONG_FRAME_BYTES;
          used_next = used - CW'(LONG_FRAME_BYTES);
          fill_next = '0;
        end
        default: fill_next = fill_inc;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < LONG_FRAME_BYTES; i++) begin
      buf_bytes_next[i] = buf_bytes[i];
      if (cmd.load) begin
        if (used[IW-1:0] == IW'(i)) begin
          buf_bytes_next[i] = rx_byte;
        end
      end else begin
        if (shift == 1 && i + 1 < LONG_FRAME_BYTES) begin
          buf_bytes_next[i] = buf_bytes[(i + 1) % LONG_FRAME_BYTES];
        end
        if (shift == SHORT_FRAME_BYTES && i + SHORT_FRAME_BYTES < LONG_FRAME_BYTES) begin
          buf_bytes_next[i] = buf_bytes[(i + SHORT_FRAME_BYTES) % LONG_FRAME_BYTES];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LONG_FRAME_BYTES; i++) begin
      buf_bytes[i] <= buf_bytes_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      used <= '0;
    end else begin
      fill <= fill_next;
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd.keep) begin
      held_valid <= 1'b1;
    end else if (cmd.push_held) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.keep) begin
      held <= found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_held) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_held) begin
      frame_len   <= held.len;
      command     <= held.command;
      payload     <= held.payload;
      last_of_run <= cmd.push_last;
    end
  end

endmodule

[rtl/serial_frame_extractor.sv]
// Top level of the serial frame extractor.
// Extracts header/tail delimited frames from a byte stream: a 4-byte short frame, or a
// LONG_FRAME_BYTES long frame when the command is the time command. A failed header is
// dropped and its gathered bytes are rescanned, so one byte may yield up to two frames.
// Each received byte passes through intake, a scan step per byte examined, a check that
// the scan has finished and a closing flush step.
// A failed long frame puts LONG_FRAME_BYTES-1 bytes back for rescan, and each failed short
// header met there is scanned up to its fourth byte and then dropped. A frame found while
// the previous one still waits for the output register stalls the scan until that
// transaction is taken.
// The scan loop handles one byte per cycle unless such a stall holds it.
// The last frame of each byte's run carries last_of_run.
module serial_frame_extractor
  import sfe_pkg::*;
#(
  parameter int LONG_FRAME_BYTES = LONG_FRAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [7:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [3:0]                 frame_len,
  output logic [7:0]                 command,
  output logic [8*PAYLOAD_BYTES-1:0] payload,
  output logic                       last_of_run
);

  sfe_cmd_t    cmd;
  sfe_status_t status;

  sfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sfe_datapath #(
    .LONG_FRAME_BYTES (LONG_FRAME_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .status      (status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .frame_len   (frame_len),
    .command     (command),
    .payload     (payload),
    .last_of_run (last_of_run)
  );

endmodule
